>>> hdl/assert_macros.svh
// assertion macros for the rtl of the signal hit table
// no dependencies; included by files that carry assertions
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define SHT_ASSERT_IMP(label, clk, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
		else $error("assertion failed");
`define SHT_ASSERT_NEXT(label, clk, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
		else $error("assertion failed");
`else
`define SHT_ASSERT_IMP(label, clk, rst_n, a, b)
`define SHT_ASSERT_NEXT(label, clk, rst_n, a, b)
`endif
`endif

>>> hdl/sht_pkg.sv
// types and constants of the signal hit table
// no dependencies; used by every module of the block
`timescale 1ns / 1ps
`default_nettype none
package sht_pkg;
	// item kinds as they arrive on the stream
	localparam logic [2:0] KIND_UPDATE  = 3'd0;
	localparam logic [2:0] KIND_BLACK   = 3'd1;
	localparam logic [2:0] KIND_WHITE   = 3'd2;
	localparam logic [2:0] KIND_STANDBY = 3'd3;
	localparam logic [2:0] KIND_CLEAR   = 3'd4;

	localparam logic [1:0] TONE_CD = 2'd1;
	localparam logic [1:0] TONE_CT = 2'd2;
	localparam logic [7:0] NO_CODE = 8'hFF;

	// register indexes on the configuration port
	localparam logic REG_MONITOR = 1'b0;
	localparam logic REG_SCAN    = 1'b1;

	typedef enum logic [2:0] {
		OP_UPDATE, OP_BLACK, OP_WHITE, OP_STANDBY, OP_CLEAR, OP_NONE
	} op_t;

	typedef enum logic [2:0] {
		ST_IDLE, ST_SEARCH, ST_UPDATE, ST_MARK_RD, ST_MARK_WR,
		ST_SWEEP_RD, ST_SWEEP_WR, ST_FINISH
	} state_t;

	typedef struct packed {
		op_t         op;
		logic [31:0] freq;
		logic [31:0] now;
		logic        open;
		logic [15:0] rssi;
		logic        black;
		logic [1:0]  tone_kind;
		logic [7:0]  tone_code;
	} item_t;

	typedef struct packed {
		logic white;
		logic black;
		logic open;
	} flags_t;

	typedef struct packed {
		logic [31:0] freq;
		logic [31:0] last_open;
		logic [31:0] duration;
		logic [15:0] rssi;
		logic [15:0] tones;
		flags_t      flags;
	} entry_t;

	typedef struct packed {
		logic monitor_mode;
		logic scan_active;
	} cfg_t;

	typedef struct packed {
		logic        found;
		logic [5:0]  index;
		logic        open_out;
		logic [7:0]  ct_out;
		logic [7:0]  cd_out;
		logic [31:0] duration_out;
	} result_t;
endpackage
`default_nettype wire

>>> hdl/sht_front.sv
// front part: accepts items, decodes their kind and queues them two deep
// depends on sht_pkg
`timescale 1ns / 1ps
`default_nettype none
module sht_front (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output logic               in_ready,
	input  wire logic [2:0]    in_kind,
	input  wire sht_pkg::item_t in_item,
	output logic               q_valid,
	input  wire logic          q_pop,
	output sht_pkg::item_t     q_item
);
	import sht_pkg::*;

	item_t       slot_q [2];
	logic        wr_ptr_q;
	logic        rd_ptr_q;
	logic [1:0]  fill_q;
	logic        push;
	item_t       dec;

	// classify the item kind
	always_comb begin
		dec = in_item;
		unique case (in_kind)
			KIND_UPDATE:  dec.op = OP_UPDATE;
			KIND_BLACK:   dec.op = OP_BLACK;
			KIND_WHITE:   dec.op = OP_WHITE;
			KIND_STANDBY: dec.op = OP_STANDBY;
			KIND_CLEAR:   dec.op = OP_CLEAR;
			default:      dec.op = OP_NONE;
		endcase
	end

	assign in_ready = (fill_q != 2'd2);
	assign push     = in_valid && in_ready;
	assign q_valid  = (fill_q != 2'd0);
	assign q_item   = slot_q[rd_ptr_q];

	// queue storage
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= dec;
		end
	end

	// queue pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			fill_q   <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= ~wr_ptr_q;
			if (q_pop) rd_ptr_q <= ~rd_ptr_q;
			fill_q <= fill_q + {1'b0, push} - {1'b0, q_pop};
		end
	end
endmodule
`default_nettype wire

>>> hdl/sht_back.sv
// back part: table memory, linear search sequencer and result register
// depends on sht_pkg and assert_macros.svh
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module sht_back #(
	parameter int ENTRIES = 64
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire sht_pkg::cfg_t  cfg,
	input  wire logic           q_valid,
	input  wire sht_pkg::item_t q_item,
	output logic                q_pop,
	output logic                res_valid,
	input  wire logic           res_ready,
	output sht_pkg::result_t    res
);
	import sht_pkg::*;

	localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int CW = $clog2(ENTRIES + 1);
	localparam logic [CW-1:0] FULL = CW'(ENTRIES);

	entry_t        mem [ENTRIES];
	entry_t        rd_q;
	state_t        st_q, st_d;
	item_t         item_q;
	logic [CW-1:0] iss_q;
	logic          cmp_vld_q;
	logic [IW-1:0] cmp_idx_q;
	logic [CW-1:0] cnt_q;
	logic [31:0]   lct_q;
	logic [IW-1:0] la_idx_q;
	logic          la_vld_q;
	logic [IW-1:0] pos_q;
	logic          new_q;
	logic          ov_q;
	result_t       res_q;

	logic          out_free;
	logic          srch_hit, srch_end;
	logic          rd_en;
	logic [IW-1:0] rd_a;
	logic          we;
	logic [IW-1:0] wa;
	entry_t        wd;
	entry_t        fresh, e_base, e_new;
	logic [31:0]   lct_eff;
	logic          gate, op_open;
	logic          res_set;
	result_t       res_d;
	logic [CW-1:0] cnt_inc;
	logic [IW+5:0] pos_x;

	assign out_free = !ov_q || res_ready;
	assign srch_hit = cmp_vld_q && (rd_q.freq == item_q.freq);
	assign srch_end = !srch_hit && (iss_q >= cnt_q);
	assign cnt_inc  = (cnt_q < FULL) ? cnt_q + CW'(1) : cnt_q;
	assign q_pop    = (st_q == ST_IDLE) && q_valid;

	// next state
	always_comb begin
		st_d = st_q;
		unique case (st_q)
			ST_IDLE: begin
				if (q_valid) begin
					unique case (q_item.op)
						OP_UPDATE:  st_d = ST_SEARCH;
						OP_BLACK,
						OP_WHITE:   st_d = la_vld_q ? ST_MARK_RD : ST_FINISH;
						OP_STANDBY: st_d = ST_SWEEP_RD;
						default:    st_d = ST_FINISH;
					endcase
				end
			end
			ST_SEARCH: begin
				if (srch_hit) st_d = ST_UPDATE;
				else if (srch_end) st_d = item_q.open ? ST_UPDATE : ST_FINISH;
			end
			ST_UPDATE:   if (out_free) st_d = ST_IDLE;
			ST_MARK_RD:  st_d = ST_MARK_WR;
			ST_MARK_WR:  st_d = ST_FINISH;
			ST_SWEEP_RD: st_d = (iss_q < cnt_q) ? ST_SWEEP_WR : ST_FINISH;
			ST_SWEEP_WR: st_d = ST_SWEEP_RD;
			ST_FINISH:   if (out_free) st_d = ST_IDLE;
			default:     st_d = ST_IDLE;
		endcase
	end

	// entry update for a hit or a new entry
	always_comb begin
		fresh           = '0;
		fresh.freq      = item_q.freq;
		fresh.last_open = item_q.now;
		fresh.tones     = {NO_CODE, NO_CODE};
		fresh.flags     = '{white: 1'b0, black: 1'b0, open: 1'b1};
		e_base  = new_q ? fresh : rd_q;
		lct_eff = new_q ? item_q.now : lct_q;
		gate    = cfg.scan_active && (e_base.flags.black ||
			(e_base.flags.white && !cfg.monitor_mode));
		op_open = item_q.open && !gate;
		e_new      = e_base;
		e_new.rssi = item_q.rssi;
		if (e_base.flags.open) e_new.duration = e_base.duration + (item_q.now - lct_eff);
		if (op_open) begin
			if (item_q.tone_code != NO_CODE) begin
				if (item_q.tone_kind == TONE_CD) e_new.tones[15:8] = item_q.tone_code;
				else if (item_q.tone_kind == TONE_CT) e_new.tones[7:0] = item_q.tone_code;
			end
			e_new.last_open = item_q.now;
		end
		e_new.flags.open = op_open;
		if (item_q.black) e_new.flags.black = 1'b1;
	end

	// memory access and result per state
	always_comb begin
		rd_en   = 1'b0;
		rd_a    = iss_q[IW-1:0];
		we      = 1'b0;
		wa      = pos_q;
		wd      = e_new;
		res_set = 1'b0;
		res_d   = '0;
		pos_x   = {6'd0, pos_q};
		unique case (st_q)
			ST_SEARCH: rd_en = !srch_hit && (iss_q < cnt_q);
			ST_UPDATE: begin
				if (out_free) begin
					we                 = 1'b1;
					res_set            = 1'b1;
					res_d.found        = 1'b1;
					res_d.index        = pos_x[5:0];
					res_d.open_out     = op_open;
					res_d.ct_out       = e_new.tones[7:0];
					res_d.cd_out       = e_new.tones[15:8];
					res_d.duration_out = e_new.duration;
				end
			end
			ST_MARK_RD: begin
				rd_en = 1'b1;
				rd_a  = la_idx_q;
			end
			ST_MARK_WR: begin
				we = 1'b1;
				wa = la_idx_q;
				wd = rd_q;
				wd.flags.black = (item_q.op == OP_BLACK);
				wd.flags.white = (item_q.op == OP_WHITE);
			end
			ST_SWEEP_RD: rd_en = (iss_q < cnt_q);
			ST_SWEEP_WR: begin
				we = 1'b1;
				wa = iss_q[IW-1:0];
				wd = rd_q;
				wd.flags.open = 1'b0;
			end
			ST_FINISH: res_set = out_free;
			default: ;
		endcase
	end

	// table memory with registered read
	always_ff @(posedge clk) begin
		if (we) mem[wa] <= wd;
		if (rd_en) rd_q <= mem[rd_a];
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (q_pop) item_q <= q_item;
		cmp_idx_q <= iss_q[IW-1:0];
		if (st_q == ST_SEARCH) begin
			if (srch_hit) begin
				pos_q <= cmp_idx_q;
				new_q <= 1'b0;
			end else if (srch_end) begin
				pos_q <= (cnt_q < FULL) ? cnt_q[IW-1:0] : IW'(cnt_q - CW'(1));
				new_q <= 1'b1;
			end
		end
		if (res_set) res_q <= res_d;
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q      <= ST_IDLE;
			iss_q     <= '0;
			cmp_vld_q <= 1'b0;
			cnt_q     <= '0;
			lct_q     <= '0;
			la_idx_q  <= '0;
			la_vld_q  <= 1'b0;
			ov_q      <= 1'b0;
		end else begin
			st_q      <= st_d;
			cmp_vld_q <= rd_en && (st_q == ST_SEARCH);
			if (q_pop) begin
				iss_q <= '0;
				if (q_item.op == OP_STANDBY) lct_q <= q_item.now;
				if (q_item.op == OP_CLEAR) cnt_q <= '0;
			end else if (rd_en && st_q == ST_SEARCH) begin
				iss_q <= iss_q + CW'(1);
			end else if (st_q == ST_SWEEP_WR) begin
				iss_q <= iss_q + CW'(1);
			end
			if (st_q == ST_SEARCH && srch_end && item_q.open) cnt_q <= cnt_inc;
			if (st_q == ST_UPDATE && out_free) begin
				lct_q <= item_q.now;
				if (e_base.flags.open) begin
					la_idx_q <= pos_q;
					la_vld_q <= 1'b1;
				end
			end
			if (res_set) ov_q <= 1'b1;
			else if (res_ready) ov_q <= 1'b0;
		end
	end

	assign res_valid = ov_q;
	assign res       = res_q;

	`SHT_ASSERT_IMP(a_cnt_bound, clk, arst_n, 1'b1, cnt_q <= FULL)
	`SHT_ASSERT_NEXT(a_la_sticky, clk, arst_n, la_vld_q, la_vld_q)
	`SHT_ASSERT_NEXT(a_res_idle, clk, arst_n, res_set, st_q == ST_IDLE)
	`SHT_ASSERT_IMP(a_pop_idle, clk, arst_n, q_pop, !we && !res_set)
endmodule
`default_nettype wire

>>> hdl/signal_hit_table_update.sv
// In an update the back part reads one stored frequency per cycle from the table
// memory until the first match or the end of the stored entries. Standby does
// one read and one write per stored entry; one item is worked at a time behind
// a two-deep queue.
// Reset clears control state and the entry count; table contents stay undefined.
`timescale 1ns / 1ps
`default_nettype none
module signal_hit_table_update #(
	parameter int ENTRIES = 64
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	// freq[31:0], now[63:32], meas_open[64], meas_rssi[80:65],
	// meas_blacklist[81], tone_code[89:82], zero fill
	input  wire logic [95:0] s_tdata,
	// kind[2:0], tone_kind[4:3]
	input  wire logic [4:0]  s_tuser,
	output logic             m_tvalid,
	input  wire logic        m_tready,
	// index[5:0], open_out[6], ct_out[14:7], cd_out[22:15], duration_out[54:23],
	// zero fill
	output logic [55:0]      m_tdata,
	// found[0]
	output logic [0:0]       m_tuser,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);
	import sht_pkg::*;

	cfg_t    cfg_q;
	item_t   in_item;
	item_t   q_item;
	logic    q_valid;
	logic    q_pop;
	result_t res;

	// configuration registers
	assign pready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (psel && penable && pwrite) begin
			if (paddr[2] == REG_MONITOR) cfg_q.monitor_mode <= pwdata[0];
			else cfg_q.scan_active <= pwdata[0];
		end
	end
	assign prdata = {31'd0, (paddr[2] == REG_SCAN) ? cfg_q.scan_active : cfg_q.monitor_mode};

	// unpack the input item
	always_comb begin
		in_item           = '0;
		in_item.op        = OP_NONE;
		in_item.freq      = s_tdata[31:0];
		in_item.now       = s_tdata[63:32];
		in_item.open      = s_tdata[64];
		in_item.rssi      = s_tdata[80:65];
		in_item.black     = s_tdata[81];
		in_item.tone_kind = s_tuser[4:3];
		in_item.tone_code = s_tdata[89:82];
	end

	sht_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.in_kind  (s_tuser[2:0]),
		.in_item  (in_item),
		.q_valid  (q_valid),
		.q_pop    (q_pop),
		.q_item   (q_item)
	);

	sht_back #(.ENTRIES(ENTRIES)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.q_valid   (q_valid),
		.q_item    (q_item),
		.q_pop     (q_pop),
		.res_valid (m_tvalid),
		.res_ready (m_tready),
		.res       (res)
	);

	// pack the result item
	assign m_tdata = {1'b0, res.duration_out, res.cd_out, res.ct_out, res.open_out, res.index};
	assign m_tuser = res.found;
endmodule
`default_nettype wire

>>> bench/tb.sv
// self-checking bench for the signal hit table: stream items in, results checked
// against a cycle-free predictor of the table; depends on sht_pkg and the rtl
`timescale 1ns / 1ps
module tb;
	import sht_pkg::*;

	localparam int DEPTH = 64;
	localparam int FL_OPEN = 0;
	localparam int FL_BLACK = 1;
	localparam int FL_WHITE = 2;

	typedef struct {
		logic [2:0]  kind;
		logic [31:0] freq;
		logic [31:0] now;
		logic        open;
		logic [15:0] rssi;
		logic        black;
		logic [1:0]  tkind;
		logic [7:0]  tcode;
	} hit_item_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [95:0] s_tdata = '0;
	logic [4:0] s_tuser = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [55:0] m_tdata;
	logic [0:0] m_tuser;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [2:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;

	// predicted table contents and control state
	logic [31:0] t_freq [DEPTH];
	logic [31:0] t_dur [DEPTH];
	logic [7:0] t_ct [DEPTH];
	logic [7:0] t_cd [DEPTH];
	logic [2:0] t_fl [DEPTH];
	int n_entries = 0;
	logic [31:0] chk_time = '0;
	int act_idx = 0;
	bit act_ok = 0;
	bit cfg_mon = 0;
	bit cfg_scan = 0;

	hit_item_t pending_q[$];
	result_t hits_expected_q[$];
	hit_item_t cur;
	int n_acc = 0;
	int errors = 0;
	bit calm;

	signal_hit_table_update u_dut (.*);

	initial begin
		forever #2 clk = ~clk;
	end

	initial begin
		#20_000_000;
		$display("Mismatches found");
		$finish;
	end

	assign calm = (n_acc >= 700) && (n_acc < 1000);

	function automatic result_t predict_hit(input hit_item_t it);
		result_t r;
		int pos;
		bit hit;
		bit op;
		r = '0;
		case (it.kind)
			KIND_UPDATE: begin
				pos = 0;
				hit = 0;
				op = it.open;
				// first matching frequency wins
				for (int i = 0; i < n_entries; i++)
					if (!hit && t_freq[i] == it.freq) begin
						pos = i;
						hit = 1;
					end
				if (!hit && !op)
					return r;
				// append, or overwrite the last slot when full
				if (!hit) begin
					if (n_entries < DEPTH)
						n_entries++;
					pos = n_entries - 1;
					chk_time = it.now;
					t_freq[pos] = it.freq;
					t_dur[pos] = '0;
					t_ct[pos] = NO_CODE;
					t_cd[pos] = NO_CODE;
					t_fl[pos] = 3'b001;
				end
				// gating while scanning
				if (cfg_scan && (t_fl[pos][FL_BLACK] || (t_fl[pos][FL_WHITE] && !cfg_mon)))
					op = 0;
				if (t_fl[pos][FL_OPEN]) begin
					t_dur[pos] = t_dur[pos] + (it.now - chk_time);
					act_idx = pos;
					act_ok = 1;
				end
				if (op && it.tcode != NO_CODE) begin
					if (it.tkind == TONE_CD)
						t_cd[pos] = it.tcode;
					else if (it.tkind == TONE_CT)
						t_ct[pos] = it.tcode;
				end
				chk_time = it.now;
				t_fl[pos][FL_OPEN] = op;
				if (it.black)
					t_fl[pos][FL_BLACK] = 1'b1;
				r.found = 1'b1;
				r.index = pos[5:0];
				r.open_out = op;
				r.ct_out = t_ct[pos];
				r.cd_out = t_cd[pos];
				r.duration_out = t_dur[pos];
			end
			KIND_BLACK: begin
				if (act_ok) begin
					t_fl[act_idx][FL_WHITE] = 1'b0;
					t_fl[act_idx][FL_BLACK] = 1'b1;
				end
			end
			KIND_WHITE: begin
				if (act_ok) begin
					t_fl[act_idx][FL_BLACK] = 1'b0;
					t_fl[act_idx][FL_WHITE] = 1'b1;
				end
			end
			KIND_STANDBY: begin
				for (int i = 0; i < n_entries; i++)
					t_fl[i][FL_OPEN] = 1'b0;
				chk_time = it.now;
			end
			KIND_CLEAR: n_entries = 0;
			default: ;
		endcase
		return r;
	endfunction

	task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
		$display("%t %s: got %h, expected %h", $realtime, what, got, want);
		errors++;
	endtask

	// driver: one item presented at a time, prediction taken at acceptance
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else begin
			if (s_tvalid && s_tready) begin
				hits_expected_q.push_back(predict_hit(cur));
				n_acc++;
			end
			if (!s_tvalid || s_tready) begin
				if (pending_q.size() > 0 && (calm || $urandom_range(0, 99) >= 34)) begin
					cur = pending_q.pop_front();
					s_tvalid <= 1'b1;
					s_tdata <= {6'd0, cur.tcode, cur.black, cur.rssi, cur.open, cur.now, cur.freq};
					s_tuser <= {cur.tkind, cur.kind};
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// monitor: random back-pressure and field by field check
	always @(posedge clk) begin
		result_t e;
		m_tready <= calm || ($urandom_range(0, 99) >= 34);
		if (arst_n && m_tvalid && m_tready) begin
			if (hits_expected_q.size() == 0) begin
				report("result with nothing expected", m_tdata[31:0], '0);
			end else begin
				e = hits_expected_q.pop_front();
				if (m_tuser[0] !== e.found)
					report("found", m_tuser[0], e.found);
				if (m_tdata[5:0] !== e.index)
					report("index", m_tdata[5:0], e.index);
				if (m_tdata[6] !== e.open_out)
					report("open_out", m_tdata[6], e.open_out);
				if (m_tdata[14:7] !== e.ct_out)
					report("ct_out", m_tdata[14:7], e.ct_out);
				if (m_tdata[22:15] !== e.cd_out)
					report("cd_out", m_tdata[22:15], e.cd_out);
				if (m_tdata[54:23] !== e.duration_out)
					report("duration_out", m_tdata[54:23], e.duration_out);
			end
		end
	end

	function automatic hit_item_t mk(input logic [2:0] kind, input logic [31:0] freq,
			input logic [31:0] now, input logic open, input logic [15:0] rssi,
			input logic black, input logic [1:0] tkind, input logic [7:0] tcode);
		hit_item_t it;
		it.kind = kind;
		it.freq = freq;
		it.now = now;
		it.open = open;
		it.rssi = rssi;
		it.black = black;
		it.tkind = tkind;
		it.tcode = tcode;
		return it;
	endfunction

	task automatic drain();
		do @(posedge clk);
		while (pending_q.size() > 0 || s_tvalid || hits_expected_q.size() > 0);
	endtask

	task automatic cfg_write(input logic idx, input logic val);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= {31'd0, val};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (idx == REG_MONITOR)
			cfg_mon = val;
		else
			cfg_scan = val;
	endtask

	// stimulus: directed items, then random phases over several settings
	initial begin
		logic [31:0] pool [80];
		logic [31:0] tnow;
		int r;
		hit_item_t it;
		bit cfgs [5][2] = '{'{0, 0}, '{1, 1}, '{0, 1}, '{1, 0}, '{0, 0}};
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		cfg_write(REG_MONITOR, 1'b0);
		cfg_write(REG_SCAN, 1'b1);

		pending_q.push_back(mk(KIND_WHITE, 0, 0, 0, 0, 0, 0, 0));
		pending_q.push_back(mk(KIND_UPDATE, 32'h1234, 10, 0, 0, 0, 0, 0));
		pending_q.push_back(mk(KIND_UPDATE, 0, 20, 1, 16'hFFFF, 0, TONE_CD, 8'd5));
		pending_q.push_back(mk(KIND_UPDATE, '1, 30, 1, 0, 0, TONE_CT, 8'd7));
		pending_q.push_back(mk(KIND_UPDATE, '1, 45, 1, 1, 0, TONE_CD, 8'd0));
		pending_q.push_back(mk(KIND_UPDATE, '1, 60, 1, 2, 0, TONE_CT, NO_CODE));
		pending_q.push_back(mk(KIND_UPDATE, '1, 70, 1, 3, 0, 2'd3, 8'd9));
		pending_q.push_back(mk(KIND_UPDATE, '1, 80, 1, 4, 0, 2'd0, 8'd11));
		pending_q.push_back(mk(KIND_BLACK, 0, 0, 0, 0, 0, 0, 0));
		pending_q.push_back(mk(KIND_UPDATE, '1, 90, 1, 5, 0, TONE_CT, 8'd12));
		pending_q.push_back(mk(KIND_WHITE, 0, 0, 0, 0, 0, 0, 0));
		pending_q.push_back(mk(KIND_UPDATE, '1, 100, 1, 6, 0, TONE_CD, 8'd13));
		pending_q.push_back(mk(KIND_UPDATE, 0, '1, 1, 7, 1, TONE_CD, 8'hFE));
		pending_q.push_back(mk(KIND_UPDATE, 0, 32'd50, 1, 8, 0, 2'd0, 0));
		pending_q.push_back(mk(KIND_STANDBY, 0, 32'd500, 0, 0, 0, 0, 0));
		pending_q.push_back(mk(KIND_UPDATE, 0, 32'd600, 0, 9, 0, 0, 0));
		pending_q.push_back(mk(3'd5, '1, '1, 1, '1, 1, 2'd3, '1));
		pending_q.push_back(mk(3'd6, 0, 0, 0, 0, 0, 0, 0));
		pending_q.push_back(mk(3'd7, 0, 0, 0, 0, 0, 0, 0));
		pending_q.push_back(mk(KIND_CLEAR, 0, 0, 0, 0, 0, 0, 0));
		pending_q.push_back(mk(KIND_UPDATE, '1, 700, 1, 0, 0, 0, 0));
		pending_q.push_back(mk(KIND_WHITE, 0, 0, 0, 0, 0, 0, 0));
		pending_q.push_back(mk(KIND_UPDATE, '1, 710, 1, 0, 0, TONE_CT, 8'd1));
		drain();

		tnow = 1000;
		for (int ph = 0; ph < 5; ph++) begin
			repeat (200) @(posedge clk);
			cfg_write(REG_MONITOR, cfgs[ph][0]);
			cfg_write(REG_SCAN, cfgs[ph][1]);
			foreach (pool[i])
				pool[i] = $urandom();
			for (int n = 0; n < 375; n++) begin
				r = $urandom_range(0, 99);
				tnow = tnow + $urandom_range(0, 2000);
				if ($urandom_range(0, 49) == 0)
					tnow = $urandom();
				it = mk(KIND_UPDATE, pool[$urandom_range(0, 79)], tnow,
					$urandom_range(0, 3) != 0, 16'($urandom()), $urandom_range(0, 19) == 0,
					2'($urandom_range(0, 3)),
					($urandom_range(0, 3) == 0) ? NO_CODE : 8'($urandom()));
				if ($urandom_range(0, 9) == 0)
					it.freq = $urandom();
				if (r >= 72 && r < 78)
					it.kind = KIND_BLACK;
				else if (r >= 78 && r < 84)
					it.kind = KIND_WHITE;
				else if (r >= 84 && r < 89)
					it.kind = KIND_STANDBY;
				else if (r >= 89 && r < 91)
					it.kind = KIND_CLEAR;
				else if (r >= 91 && r < 94)
					it.kind = 3'($urandom_range(5, 7));
				pending_q.push_back(it);
				// hold the sender until the table has answered everything
				if (n == 180)
					drain();
			end
			drain();
		end
		repeat (300) @(posedge clk);
		if (errors == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end
endmodule
